>>> rtl/core/blist_pkg.sv
// Shared constants, types and codes for the bounded indexed list.
package blist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [MODE_W-1:0] {
    MD_APPEND     = 3'd0,
    MD_PREPEND    = 3'd1,
    MD_INSERT     = 3'd2,
    MD_REMOVE     = 3'd3,
    MD_READ       = 3'd4,
    MD_TAKE_FIRST = 3'd5,
    MD_TAKE_LAST  = 3'd6,
    MD_CLEAR      = 3'd7
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } seq_state_t;

  // One result as it leaves the sequencer
  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               is_empty;
  } res_t;

endpackage

>>> rtl/core/blist_ram.sv
// Element store: one write port, one read port with registered read data.
module blist_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [blist_pkg::IDX_W-1:0]      waddr,
  input  logic [blist_pkg::DATA_WIDTH-1:0] wdata,
  input  logic [blist_pkg::IDX_W-1:0]      raddr,
  output logic [blist_pkg::DATA_WIDTH-1:0] rdata
);
  import blist_pkg::*;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/blist_seq.sv
// Command decode and element mover: shifts one element per cycle through the store.
module blist_seq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            req_vld,
  output logic                            req_rdy,
  input  blist_pkg::mode_t                req_mode,
  input  logic [blist_pkg::POS_W-1:0]     req_pos,
  input  logic [blist_pkg::VALUE_W-1:0]   req_value,
  output logic                            res_vld,
  input  logic                            res_rdy,
  output blist_pkg::res_t                 res
);
  import blist_pkg::*;

  seq_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      len_r, len_nxt;
  logic                  ins_r, ins_nxt;       // insert family, else remove family
  logic                  dec_r, dec_nxt;       // shrink the list at the end
  logic                  ret_r, ret_nxt;       // return the element taken
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]      src_r, src_nxt;
  logic [IDX_W-1:0]      end_r, end_nxt;
  logic                  issue_r, issue_nxt;
  logic                  pend_r, pend_nxt;
  logic [IDX_W-1:0]      paddr_r, paddr_nxt;
  logic [DATA_WIDTH-1:0] rd_r, rd_nxt;
  status_t               st_r, st_nxt;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CMP_W-1:0]      pos_x, len_x;
  logic                  full, empty;
  logic [IDX_W-1:0]      last_idx;

  blist_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (src_r),
    .rdata (ram_rdata)
  );

  assign pos_x    = CMP_W'(req_pos);
  assign len_x    = CMP_W'(len_r);
  assign full     = (len_r == CNT_W'(CAPACITY));
  assign empty    = (len_r == '0);
  assign last_idx = IDX_W'(len_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r   <= ins_nxt;
    dec_r   <= dec_nxt;
    ret_r   <= ret_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    src_r   <= src_nxt;
    end_r   <= end_nxt;
    paddr_r <= paddr_nxt;
    rd_r    <= rd_nxt;
    st_r    <= st_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    ins_nxt   = ins_r;
    dec_nxt   = dec_r;
    ret_nxt   = ret_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    src_nxt   = src_r;
    end_nxt   = end_r;
    issue_nxt = issue_r;
    pend_nxt  = 1'b0;
    paddr_nxt = paddr_r;
    rd_nxt    = rd_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_r;
    req_rdy   = 1'b0;
    res_vld   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        req_rdy = 1'b1;
        if (req_vld) begin
          st_nxt    = ST_OK;
          rd_nxt    = '0;
          val_nxt   = DATA_WIDTH'(req_value);
          dec_nxt   = 1'b1;
          ins_nxt   = 1'b0;
          ret_nxt   = 1'b1;
          issue_nxt = 1'b1;
          state_nxt = S_RUN;
          unique case (req_mode)
            MD_APPEND, MD_PREPEND, MD_INSERT: begin
              ins_nxt = 1'b1;
              src_nxt = last_idx;
              if (req_mode == MD_APPEND) begin
                pos_nxt   = IDX_W'(len_r);
                issue_nxt = 1'b0;
              end else if (req_mode == MD_PREPEND) begin
                pos_nxt   = '0;
                issue_nxt = !empty;
              end else begin
                pos_nxt   = IDX_W'(req_pos);
                issue_nxt = (pos_x < len_x);
              end
              end_nxt = pos_nxt;
              if (req_mode == MD_INSERT && pos_x > len_x) begin
                st_nxt = ST_BAD_INDEX;
              end else if (full) begin
                st_nxt = ST_FULL;
              end
            end
            MD_REMOVE: begin
              ret_nxt = 1'b0;
              pos_nxt = IDX_W'(req_pos);
              src_nxt = IDX_W'(req_pos);
              end_nxt = last_idx;
              if (empty) begin
                st_nxt = (req_pos == '0) ? ST_EMPTY : ST_BAD_INDEX;
              end else if (pos_x >= len_x) begin
                st_nxt = ST_BAD_INDEX;
              end
            end
            MD_READ: begin
              dec_nxt = 1'b0;
              pos_nxt = IDX_W'(req_pos);
              src_nxt = IDX_W'(req_pos);
              end_nxt = IDX_W'(req_pos);
              if (pos_x >= len_x) begin
                st_nxt = ST_BAD_INDEX;
              end
            end
            MD_TAKE_FIRST: begin
              pos_nxt = '0;
              src_nxt = '0;
              end_nxt = last_idx;
              if (empty) begin
                st_nxt = ST_EMPTY;
              end
            end
            MD_TAKE_LAST: begin
              pos_nxt = last_idx;
              src_nxt = last_idx;
              end_nxt = last_idx;
              if (empty) begin
                st_nxt = ST_EMPTY;
              end
            end
            MD_CLEAR: begin
              len_nxt = '0;
              st_nxt  = ST_OK;
            end
          endcase
          // Failed commands and clear finish at once
          if (st_nxt != ST_OK || req_mode == MD_CLEAR) begin
            issue_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end

      S_RUN: begin
        // Retire the element read last cycle
        if (pend_r) begin
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_waddr = paddr_r + 1'b1;
            ram_wdata = ram_rdata;
          end else if (paddr_r == pos_r) begin
            // drop the element a remove takes out
            if (ret_r) begin
              rd_nxt = ram_rdata;
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = paddr_r - 1'b1;
            ram_wdata = ram_rdata;
          end
        end
        // Issue the next source read
        if (issue_r) begin
          pend_nxt  = 1'b1;
          paddr_nxt = src_r;
          if (src_r == end_r) begin
            issue_nxt = 1'b0;
          end else if (ins_r) begin
            src_nxt = src_r - 1'b1;
          end else begin
            src_nxt = src_r + 1'b1;
          end
        end else if (!pend_r) begin
          if (ins_r) begin
            ram_we    = 1'b1;
            ram_waddr = pos_r;
            ram_wdata = val_r;
            len_nxt   = len_r + 1'b1;
          end else if (dec_r) begin
            len_nxt = len_r - 1'b1;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        res_vld = 1'b1;
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.read_value = VALUE_W'(rd_r);
  assign res.status     = st_r;
  assign res.count      = COUNT_W'(len_r);
  assign res.is_empty   = (len_r == '0);

endmodule

>>> rtl/core/bounded_indexed_list.sv
// Bounded indexed list: top level with stream ports and the result register.
// A failed request or a clear goes straight to the result; an insert or push that
// shifts nothing writes its value first; any other request first streams its elements
// through the store, the mover reading one element a cycle. One request at a time:
// the next is taken in the cycle after the result enters the output register.
// Reset (rst_n low, synchronous) empties the list; element words are not cleared.
module bounded_indexed_list (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode [2:0], position [7:3], value [39:8]
  input  logic [blist_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // read_value [31:0], status [33:32], count [38:34], is_empty [39]
  output logic [blist_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import blist_pkg::*;

  res_t res;
  logic res_vld;
  logic res_rdy;
  logic out_vld_r, out_vld_nxt;
  res_t out_res_r, out_res_nxt;

  blist_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_vld   (in_tvalid),
    .req_rdy   (in_tready),
    .req_mode  (mode_t'(in_tdata[2:0])),
    .req_pos   (in_tdata[7:3]),
    .req_value (in_tdata[39:8]),
    .res_vld   (res_vld),
    .res_rdy   (res_rdy),
    .res       (res)
  );

  // Take a new result whenever the register is empty or being drained
  assign res_rdy = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (res_rdy) begin
      out_vld_nxt = res_vld;
      out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_res_r.is_empty, out_res_r.count, out_res_r.status,
                       out_res_r.read_value};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[38:34] <= COUNT_W'(CAPACITY)))
    else $error("result count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39] == (out_tdata[38:34] == '0)))
    else $error("empty flag disagrees with count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] == ST_FULL) |-> (out_tdata[38:34] == COUNT_W'(CAPACITY)))
    else $error("full status with list not full");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[33:32] != ST_OK) |-> (out_tdata[31:0] == '0))
    else $error("failed request returned data");

endmodule

>>> tb/testbench.sv
// Self-checking stream testbench for the bounded indexed list.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import blist_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 25;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 280;
  localparam int SLOT_W       = 11;

  typedef struct packed {
    mode_t              mode;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [CAPACITY-1:0][DATA_WIDTH-1:0] words;
    logic [COUNT_W-1:0]                  len;
  } list_state_t;

  typedef struct packed {
    list_state_t s;
    res_t        r;
  } list_step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Ring buffers: pending requests and expected results
  list_cmd_t   cmd_buf [2**SLOT_W];
  res_t        res_buf [2**SLOT_W];
  logic [SLOT_W-1:0] cmd_wr = '0;
  logic [SLOT_W-1:0] cmd_rd = '0;
  logic [SLOT_W-1:0] res_wr = '0;
  logic [SLOT_W-1:0] res_rd = '0;
  list_cmd_t   cur_cmd;
  list_state_t model_list = '0;
  list_state_t gen_list = '0;
  list_step_t  model_step;
  res_t        want;
  logic        growing = 1'b1;
  logic        pressure_on = 1'b0;
  logic        hold_served = 1'b0;
  int          hold_left = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          errors = 0;
  int          cycles = 0;

  bounded_indexed_list dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Next list contents and the result one command gives
  function automatic list_step_t list_apply(list_state_t s, list_cmd_t c);
    list_step_t o;
    int n;
    int p;
    int i;
    n = s.len;
    p = c.pos;
    o.r.read_value = '0;
    o.r.status = ST_OK;
    case (c.mode)
      MD_APPEND, MD_PREPEND, MD_INSERT: begin
        if (c.mode == MD_APPEND) p = n;
        else if (c.mode == MD_PREPEND) p = 0;
        // index is checked before capacity
        if (p > n) o.r.status = ST_BAD_INDEX;
        else if (n >= CAPACITY) o.r.status = ST_FULL;
        else begin
          for (i = n; i > p; i--) s.words[i] = s.words[i-1];
          s.words[p] = c.value[DATA_WIDTH-1:0];
          n++;
        end
      end
      MD_REMOVE, MD_TAKE_FIRST, MD_TAKE_LAST: begin
        if (n == 0) begin
          if (c.mode == MD_REMOVE && p != 0) o.r.status = ST_BAD_INDEX;
          else o.r.status = ST_EMPTY;
        end else begin
          if (c.mode == MD_TAKE_FIRST) p = 0;
          else if (c.mode == MD_TAKE_LAST) p = n - 1;
          if (p >= n) o.r.status = ST_BAD_INDEX;
          else begin
            if (c.mode != MD_REMOVE) o.r.read_value = VALUE_W'(s.words[p]);
            for (i = p; i + 1 < n; i++) s.words[i] = s.words[i+1];
            n--;
          end
        end
      end
      MD_READ: begin
        if (p >= n) o.r.status = ST_BAD_INDEX;
        else o.r.read_value = VALUE_W'(s.words[p]);
      end
      MD_CLEAR: n = 0;
    endcase
    s.len = COUNT_W'(n);
    o.s = s;
    o.r.count = COUNT_W'(n);
    o.r.is_empty = (n == 0);
    return o;
  endfunction

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Driver: hold each request until it is taken, then fetch the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (cmd_rd == res_wr) begin
      if (cmd_wr != cmd_rd && $urandom_range(0, 99) >= tx_idle_pct) begin
        cur_cmd = cmd_buf[cmd_rd];
        cmd_rd = cmd_rd + 1'b1;
        in_tdata <= {cur_cmd.value, cur_cmd.pos, cur_cmd.mode};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted on its own
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (pressure_on && !hold_served) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || hold_left != 0) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        model_step = list_apply(model_list, cur_cmd);
        model_list = model_step.s;
        res_buf[res_wr] = model_step.r;
        res_wr = res_wr + 1'b1;
      end
      if (out_tvalid && out_tready) begin
        if (res_rd == res_wr) begin
          report($sformatf("result with nothing pending, data %h", out_tdata));
        end else begin
          want = res_buf[res_rd];
          res_rd = res_rd + 1'b1;
          if (out_tdata[31:0] !== want.read_value)
            report($sformatf("read_value %h, want %h", out_tdata[31:0], want.read_value));
          if (out_tdata[33:32] !== want.status)
            report($sformatf("status %0d, want %0d", out_tdata[33:32], want.status));
          if (out_tdata[38:34] !== want.count)
            report($sformatf("count %0d, want %0d", out_tdata[38:34], want.count));
          if (out_tdata[39] !== want.is_empty)
            report($sformatf("is_empty %b, want %b", out_tdata[39], want.is_empty));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_cmd(input mode_t m, input int p, input logic [VALUE_W-1:0] v);
    list_cmd_t  c;
    list_step_t g;
    c.mode = m;
    c.pos = p[POS_W-1:0];
    c.value = v;
    // track the length so that most indexes land in range
    g = list_apply(gen_list, c);
    gen_list = g.s;
    cmd_buf[cmd_wr] = c;
    cmd_wr = cmd_wr + 1'b1;
  endtask

  task automatic queue_random(input int n);
    int    k;
    int    r;
    int    len;
    int    p;
    mode_t m;
    logic [VALUE_W-1:0] v;
    for (k = 0; k < n; k++) begin
      len = gen_list.len;
      if (len == CAPACITY) growing = 1'b0;
      else if (len == 0) growing = 1'b1;
      else if ($urandom_range(0, 49) == 0) growing = !growing;
      r = $urandom_range(0, 99);
      if (r < 2) m = MD_CLEAR;
      else if (r < 14) m = MD_READ;
      else if (r < 22) m = MD_INSERT;
      else begin
        case ($urandom_range(0, 3))
          0: m = growing ? MD_APPEND  : MD_REMOVE;
          1: m = growing ? MD_PREPEND : MD_TAKE_FIRST;
          2: m = growing ? MD_INSERT  : MD_TAKE_LAST;
          default: m = growing ? MD_APPEND : MD_REMOVE;
        endcase
      end
      if ($urandom_range(0, 9) == 0) p = $urandom_range(0, 31);
      else if (m == MD_INSERT) p = $urandom_range(0, len);
      else if (len == 0) p = 0;
      else p = $urandom_range(0, len - 1);
      r = $urandom_range(0, 9);
      if (r == 0) v = '0;
      else if (r == 1) v = '1;
      else v = $urandom;
      queue_cmd(m, p, v);
    end
  endtask

  task automatic wait_idle();
    while (cmd_wr != res_wr || res_wr != res_rd)
      @(posedge clk);
  endtask

  initial begin
    int k;
    int ph;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list corner cases
    queue_cmd(MD_TAKE_FIRST, 0, '0);
    queue_cmd(MD_TAKE_LAST, 0, '0);
    queue_cmd(MD_REMOVE, 0, '0);
    queue_cmd(MD_REMOVE, 31, '0);
    queue_cmd(MD_READ, 0, '0);
    queue_cmd(MD_INSERT, 1, '1);
    queue_cmd(MD_INSERT, 0, '1);
    // fill to capacity through every way in
    for (k = 0; k < CAPACITY - 1; k++) begin
      case (k % 3)
        0: queue_cmd(MD_APPEND, 0, (k == 0) ? '0 : $urandom);
        1: queue_cmd(MD_PREPEND, 0, $urandom);
        default: queue_cmd(MD_INSERT, $urandom_range(0, gen_list.len), $urandom);
      endcase
    end
    queue_cmd(MD_PREPEND, 0, $urandom);
    queue_cmd(MD_INSERT, CAPACITY + 1, $urandom);
    queue_cmd(MD_INSERT, CAPACITY, $urandom);
    queue_cmd(MD_READ, CAPACITY - 1, '0);
    queue_cmd(MD_REMOVE, CAPACITY - 1, '0);
    queue_cmd(MD_TAKE_FIRST, 0, '0);
    queue_cmd(MD_TAKE_LAST, 0, '0);
    queue_cmd(MD_CLEAR, 0, '0);
    wait_idle();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        1: begin tx_idle_pct = 60; rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_idle_pct = 60; end
        default: begin tx_idle_pct = 9; rx_idle_pct = 9; end
      endcase
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    // back up the block while requests keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pressure_on = 1'b1;
    queue_random(60);
    wait_idle();
    pressure_on = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/blist_pkg.sv
rtl/core/blist_ram.sv
rtl/core/blist_seq.sv
rtl/core/bounded_indexed_list.sv
tb/testbench.sv
